@@ rtl/core/bm25_pkg.sv @@
// ============================================================================
// bm25_pkg
// Shared types and constants for the BM25 document scorer.
// ============================================================================
package bm25_pkg;

  localparam int VOCAB_DEPTH = 16384;
  localparam int DOC_DEPTH   = 4096;
  localparam int TERM_AW     = $clog2(VOCAB_DEPTH);
  localparam int DOC_AW      = $clog2(DOC_DEPTH);

  localparam logic [1:0] MODE_LOAD_IDF = 2'd0;
  localparam logic [1:0] MODE_LOAD_LEN = 2'd1;
  localparam logic [1:0] MODE_SCORE    = 2'd2;

  localparam logic [1:0] CFG_K1  = 2'd0;
  localparam logic [1:0] CFG_B   = 2'd1;
  localparam logic [1:0] CFG_AVG = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [13:0]        term_index;
    logic [11:0]        doc_index;
    logic signed [31:0] load_value;
    logic [15:0]        term_freq;
    logic               last_term;
  } bm25_in_t;

  typedef struct packed {
    logic [11:0]        scored_doc;
    logic signed [31:0] doc_score;
  } bm25_out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_DIV1, ST_NORM, ST_NORM_HI, ST_KDEN, ST_KDEN_HI,
    ST_NUM1, ST_NUM2, ST_NUM2_HI, ST_DIV2, ST_ACC
  } bm25_state_t;

endpackage

@@ rtl/core/bm25_document_scorer_unit.sv @@
// ============================================================================
// bm25_document_scorer_unit
// Fixed-point Okapi BM25 scorer with idf and document length tables.
// ============================================================================
// Load words (idf, length) are taken one per cycle while the block is idle
// and no score waits to be taken. A score word keeps the block busy through
// two serial restoring divisions on one shared 64-bit divider (64 steps each)
// with seven steps on one shared 32x32 multiplier between them. The block is
// not ready while a word is in progress, and a score word on the last term
// holds off input until it is taken. No clearing pass.
module bm25_document_scorer_unit
  import bm25_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  bm25_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output bm25_out_t out_data,
  input  logic      cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);
  localparam logic signed [47:0] SUM_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] SUM_MIN = {1'b1, {47{1'b0}}};

  bm25_state_t state_r, state_nxt;
  logic [15:0] k1_r;
  logic [12:0] b_r;
  logic [23:0] avg_r;
  bm25_in_t    item_r;
  logic signed [47:0] sum_r, sum_nxt;
  bm25_out_t   out_r;
  logic        out_valid_r;

  // shared divider
  logic [63:0] dvd_r, quo_r;
  logic [64:0] rem_r;
  logic [63:0] dvs_r;
  logic [6:0]  cnt_r;
  // shared multiplier operands / results
  logic [31:0] ma, mb;
  logic [63:0] mp;
  logic [63:0] t_r;
  logic [63:0] p_r;
  logic [31:0] mag_r;
  logic        neg_r, idf_ok_r, len_ok_r;

  logic [31:0] idf_q;
  logic [15:0] len_q;
  logic        idf_we, len_we;
  logic [15:0] len_sat;

  always_comb begin
    if (in_data.load_value[31])
      len_sat = '0;
    else if (in_data.load_value > 32'sd65535)
      len_sat = 16'hFFFF;
    else
      len_sat = in_data.load_value[15:0];
  end

  logic acc;
  assign in_ready = (state_r == ST_IDLE) && !out_valid_r;
  assign acc      = in_valid && in_ready;
  assign idf_we   = acc && in_data.mode == MODE_LOAD_IDF &&
                    {18'd0, in_data.term_index} < 32'(VOCAB_DEPTH);
  assign len_we   = acc && in_data.mode == MODE_LOAD_LEN &&
                    {20'd0, in_data.doc_index} < 32'(DOC_DEPTH);

  bm25_ram #(.WIDTH(32), .DEPTH(VOCAB_DEPTH)) u_idf (
    .clk(clk), .we(idf_we), .waddr(in_data.term_index[TERM_AW-1:0]),
    .wdata(in_data.load_value), .raddr(in_data.term_index[TERM_AW-1:0]),
    .rdata(idf_q));
  bm25_ram #(.WIDTH(16), .DEPTH(DOC_DEPTH)) u_len (
    .clk(clk), .we(len_we), .waddr(in_data.doc_index[DOC_AW-1:0]),
    .wdata(len_sat), .raddr(in_data.doc_index[DOC_AW-1:0]),
    .rdata(len_q));

  logic [12:0] bsat;
  logic [31:0] idf_v, mag;
  logic [15:0] len_v;
  assign bsat  = (b_r > 13'd4096) ? 13'd4096 : b_r;
  assign idf_v = idf_ok_r ? idf_q : '0;
  assign len_v = len_ok_r ? len_q : '0;
  assign mag   = idf_v[31] ? (32'd0 - idf_v) : idf_v;

  // wide products are built from a low and a high 32-bit pass
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_r)
      ST_NORM:    begin ma = {19'd0, bsat}; mb = quo_r[31:0]; end
      ST_NORM_HI: begin ma = {19'd0, bsat}; mb = quo_r[63:32]; end
      ST_KDEN:    begin ma = {16'd0, k1_r}; mb = t_r[31:0]; end
      ST_KDEN_HI: begin ma = {16'd0, k1_r}; mb = t_r[63:32]; end
      ST_NUM1: begin ma = {16'd0, item_r.term_freq}; mb = {15'd0, {1'b0, k1_r} + 17'd4096}; end
      ST_NUM2:    begin ma = mag_r; mb = t_r[31:0]; end
      ST_NUM2_HI: begin ma = mag_r; mb = t_r[63:32]; end
      default: ;
    endcase
  end
  assign mp = {32'd0, ma} * {32'd0, mb};

  // divider step
  logic [64:0] rsh;
  assign rsh = {rem_r[63:0], dvd_r[63]};

  // contribution
  logic [47:0] qcl;
  logic signed [48:0] s49;
  assign qcl = (quo_r > 64'h8000_0000_0000) ? 48'h8000_0000_0000 : quo_r[47:0];
  always_comb begin
    logic signed [48:0] c;
    if (dvs_r == '0)
      c = '0;
    else if (neg_r)
      c = -$signed({1'b0, qcl});
    else
      c = $signed({1'b0, qcl});
    s49 = {sum_r[47], sum_r} + c;
    if (s49 > $signed({SUM_MAX[47], SUM_MAX}))
      sum_nxt = SUM_MAX;
    else if (s49 < $signed({SUM_MIN[47], SUM_MIN}))
      sum_nxt = SUM_MIN;
    else
      sum_nxt = s49[47:0];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (acc && in_data.mode == MODE_SCORE) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_DIV1;
      ST_DIV1: if (cnt_r == 7'd0) state_nxt = ST_NORM;
      ST_NORM: state_nxt = ST_NORM_HI;
      ST_NORM_HI: state_nxt = ST_KDEN;
      ST_KDEN: state_nxt = ST_KDEN_HI;
      ST_KDEN_HI: state_nxt = ST_NUM1;
      ST_NUM1: state_nxt = ST_NUM2;
      ST_NUM2: state_nxt = ST_NUM2_HI;
      ST_NUM2_HI: state_nxt = ST_DIV2;
      ST_DIV2: if (cnt_r == 7'd0) state_nxt = ST_ACC;
      ST_ACC:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k1_r        <= 16'd6144;
      b_r         <= 13'd3072;
      avg_r       <= 24'd256;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_K1:  k1_r  <= cfg_wdata[15:0];
          CFG_B:   b_r   <= cfg_wdata[12:0];
          CFG_AVG: avg_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (state_r == ST_ACC) begin
        if (item_r.last_term) begin
          sum_r       <= '0;
          out_valid_r <= 1'b1;
        end else begin
          sum_r <= sum_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      item_r   <= in_data;
      idf_ok_r <= {18'd0, in_data.term_index} < 32'(VOCAB_DEPTH);
      len_ok_r <= {20'd0, in_data.doc_index} < 32'(DOC_DEPTH);
    end
    unique case (state_r)
      ST_READ: begin
        dvd_r <= {28'd0, len_v, 20'd0};
        dvs_r <= {40'd0, (avg_r == '0) ? 24'd1 : avg_r};
        rem_r <= '0; quo_r <= '0; cnt_r <= 7'd63;
        neg_r <= idf_v[31];
        mag_r <= mag;
      end
      ST_DIV1, ST_DIV2: begin
        dvd_r <= {dvd_r[62:0], 1'b0};
        if (rsh >= {1'b0, dvs_r}) begin
          rem_r <= rsh - {1'b0, dvs_r}; quo_r <= {quo_r[62:0], 1'b1};
        end else begin
          rem_r <= rsh; quo_r <= {quo_r[62:0], 1'b0};
        end
        if (cnt_r != 7'd0) cnt_r <= cnt_r - 7'd1;
      end
      ST_NORM: t_r <= mp;
      ST_NORM_HI:
        t_r <= {32'd0, 32'd4096 - {19'd0, bsat}} + (({mp[31:0], 32'd0} + t_r) >> 12);
      ST_KDEN: p_r <= mp;
      ST_KDEN_HI: t_r <= ({mp[31:0], 32'd0} + p_r) >> 12;
      ST_NUM1: begin
        dvs_r <= {20'd0, item_r.term_freq, 12'd0} + t_r;
        t_r   <= mp;
      end
      ST_NUM2: p_r <= mp;
      ST_NUM2_HI: begin
        dvd_r <= {mp[31:0], 32'd0} + p_r; rem_r <= '0; quo_r <= '0; cnt_r <= 7'd63;
      end
      ST_ACC: begin
        out_r.scored_doc <= item_r.doc_index;
        if (sum_nxt > 48'sh0000_7FFF_FFFF)
          out_r.doc_score <= 32'sh7FFF_FFFF;
        else if (sum_nxt < -48'sh0000_8000_0000)
          out_r.doc_score <= 32'sh8000_0000;
        else
          out_r.doc_score <= sum_nxt[31:0];
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule

@@ rtl/core/bm25_ram.sv @@
// ============================================================================
// bm25_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ============================================================================
module bm25_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
